[sv/sots_pkg.sv]
// Package for the sum-of-two-squares tester.
// Holds default parameters and shared command and status types.
`timescale 1ns / 1ps
package sots_pkg;
    localparam int SieveLimitDef = 65536;
    localparam int TableDepthDef = 4096;
    localparam int ValueWidthDef = 32;

    typedef struct packed {
        logic sieve_start;
        logic test_start;
    } t_cmd;

    typedef struct packed {
        logic sieve_done;
        logic test_done;
        logic test_result;
    } t_status;
endpackage

[sv/sots_datapath.sv]
// Datapath: sieve bitmap, prime table, trial divider and test sequencer.
// Depends on sots_pkg for command and status types.
`timescale 1ns / 1ps
module sots_datapath
    import sots_pkg::*;
#(
    parameter int SIEVE_LIMIT = SieveLimitDef,
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int VALUE_WIDTH = ValueWidthDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output t_status                o_status
);
    localparam int SW = $clog2(SIEVE_LIMIT);
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int PW = SW + 1;
    localparam int CW = TW + 1;
    localparam int DW = (VALUE_WIDTH > 2 * PW) ? VALUE_WIDTH : 2 * PW;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_OUTER, S_OREAD, S_MARK, S_COLLECT, S_CREAD,
        S_STRIP, S_FETCH, S_FWAIT, S_SQ, S_DIV, S_FINAL
    } t_dstate;

    logic           r_map [SIEVE_LIMIT];
    logic [PW-1:0]  r_tab [TABLE_DEPTH];
    t_dstate        r_st;
    logic [PW-1:0]  r_i;
    logic [PW:0]    r_j;
    logic           r_mrd;
    logic [PW-1:0]  r_trd;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_k;
    logic [PW-1:0]  r_p;
    logic [DW-1:0]  r_rest;
    logic [DW-1:0]  r_quo;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_dvd;
    logic [$clog2(DW+1)-1:0] r_bit;
    logic           r_odd;
    logic           r_sdone;
    logic           r_tdone;
    logic           r_res;
    logic [DW:0]    n_rem;
    logic           n_qbit;
    logic [DW-1:0]  n_quo;

    assign n_rem  = {r_rem, r_dvd[DW-1]};
    assign n_qbit = (n_rem >= (DW + 1)'(r_p));
    assign n_quo  = {r_quo[DW-2:0], n_qbit};
    assign o_status = '{sieve_done: r_sdone, test_done: r_tdone, test_result: r_res};

    always_ff @(posedge i_clk) begin
        r_mrd <= r_map[r_i[SW-1:0]];
        r_trd <= r_tab[r_k[TW-1:0]];
        if (r_st == S_CLR) begin
            r_map[r_i[SW-1:0]] <= (r_i >= PW'(2));
        end else if (r_st == S_MARK) begin
            r_map[r_j[SW-1:0]] <= 1'b0;
        end
        if (r_st == S_COLLECT && r_mrd && r_i[1:0] == 2'b11
                && r_cnt < CW'(TABLE_DEPTH)) begin
            r_tab[r_cnt[TW-1:0]] <= r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_sdone <= 1'b0;
            r_tdone <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_sdone <= 1'b0;
            r_tdone <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_cmd.sieve_start) begin
                        r_i  <= '0;
                        r_st <= S_CLR;
                    end else if (i_cmd.test_start) begin
                        r_rest <= DW'(i_value);
                        if (i_value <= VALUE_WIDTH'(1)) begin
                            r_res <= 1'b1; r_tdone <= 1'b1;
                        end else begin
                            r_k <= '0; r_st <= S_STRIP;
                        end
                    end
                end
                S_CLR: begin
                    if (r_i == PW'(SIEVE_LIMIT - 1)) begin
                        r_i <= PW'(2); r_st <= S_OREAD;
                    end else r_i <= r_i + 1'b1;
                end
                S_OREAD: r_st <= S_OUTER;
                S_OUTER: begin
                    if ((2 * PW)'(r_i) * (2 * PW)'(r_i) >= (2 * PW)'(SIEVE_LIMIT)) begin
                        r_i <= PW'(2); r_cnt <= '0; r_st <= S_CREAD;
                    end else if (r_mrd) begin
                        r_j  <= (PW + 1)'((2 * PW)'(r_i) * (2 * PW)'(r_i));
                        r_st <= S_MARK;
                    end else begin
                        r_i <= r_i + 1'b1; r_st <= S_OREAD;
                    end
                end
                S_MARK: begin
                    if (r_j + (PW + 1)'(r_i) >= (PW + 1)'(SIEVE_LIMIT)) begin
                        r_i <= r_i + 1'b1; r_st <= S_OREAD;
                    end else r_j <= r_j + (PW + 1)'(r_i);
                end
                S_CREAD: r_st <= S_COLLECT;
                S_COLLECT: begin
                    if (r_mrd && r_i[1:0] == 2'b11 && r_cnt < CW'(TABLE_DEPTH))
                        r_cnt <= r_cnt + 1'b1;
                    if (r_i == PW'(SIEVE_LIMIT - 1)) begin
                        r_sdone <= 1'b1; r_st <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1; r_st <= S_CREAD;
                    end
                end
                S_STRIP: begin
                    if (!r_rest[0]) r_rest <= r_rest >> 1;
                    else r_st <= S_FETCH;
                end
                S_FETCH: begin
                    if (r_k >= r_cnt) r_st <= S_FINAL;
                    else r_st <= S_FWAIT;
                end
                S_FWAIT: begin
                    r_p <= r_trd; r_odd <= 1'b0; r_st <= S_SQ;
                end
                S_SQ: begin
                    if (DW'((2 * PW)'(r_p) * (2 * PW)'(r_p)) > r_rest
                            || (2 * PW)'(r_p) * (2 * PW)'(r_p) > (2 * PW)'(r_rest)
                               && DW == 2 * PW) begin
                        r_st <= S_FINAL;
                    end else begin
                        r_dvd <= r_rest; r_rem <= '0; r_quo <= '0;
                        r_bit <= '0; r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == ($clog2(DW+1))'(DW - 1)) begin
                        if (n_rem == (DW + 1)'(r_p) || DW'(n_rem) == '0
                                && n_rem < (DW + 1)'(r_p)) begin
                            r_rest <= n_quo;
                            r_dvd  <= n_quo;
                            r_rem  <= '0;
                            r_quo  <= '0;
                            r_bit  <= '0;
                            r_odd  <= ~r_odd;
                        end else if (r_odd) begin
                            r_res <= 1'b0; r_tdone <= 1'b1; r_st <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1; r_st <= S_FETCH;
                        end
                    end else begin
                        r_dvd <= r_dvd << 1;
                        if (n_qbit) begin
                            r_rem <= DW'(n_rem - (DW + 1)'(r_p));
                        end else begin
                            r_rem <= DW'(n_rem);
                        end
                        r_quo <= n_quo;
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_FINAL: begin
                    r_res   <= !(r_rest > DW'(1) && r_rest[1:0] == 2'b11) && !r_odd;
                    r_tdone <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

[sv/sots_ctrl.sv]
// Controller: runs the sieve after reset, then hands items to the datapath.
// Depends on sots_pkg for command and status types.
`timescale 1ns / 1ps
module sots_ctrl
    import sots_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output logic    o_result
);
    typedef enum logic [1:0] {C_INIT, C_SIEVE, C_READY, C_TEST} t_cstate;

    t_cstate r_st;
    logic    r_valid;
    logic    r_result;

    assign o_cmd.sieve_start = (r_st == C_INIT);
    assign o_cmd.test_start  = (r_st == C_READY) && i_start;
    assign o_busy   = (r_st != C_READY);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= C_INIT;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_st)
                C_INIT:  r_st <= C_SIEVE;
                C_SIEVE: if (i_status.sieve_done) r_st <= C_READY;
                C_READY: if (i_start) r_st <= C_TEST;
                C_TEST: begin
                    if (i_status.test_done) begin
                        r_valid  <= 1'b1;
                        r_result <= i_status.test_result;
                        r_st     <= C_READY;
                    end
                end
                default: r_st <= C_INIT;
            endcase
        end
    end
endmodule

[sv/sum_of_two_squares_test_top.sv]
// Top level of the sum-of-two-squares tester.
// Depends on sots_pkg, sots_ctrl and sots_datapath.
//
// Usage: after reset the block sieves all integers below SIEVE_LIMIT and
// stores the primes of the form 4k+3 in a table. The sieve clears the bitmap
// entry by entry, crosses off the multiples of each prime and then collects
// the table entry by entry; busy stays high meanwhile. An item is accepted
// when start is high and busy is low. The value has its factors of two
// stripped, then is trial divided by the table primes with a bit-serial
// divider DW bits wide, DW being the wider of VALUE_WIDTH and twice the
// prime width (34 at the defaults). Each table prime whose square does not
// exceed the rest costs one division, and each factor found costs one more
// division. Values of zero and one are answered without any division; a
// large prime value walks about 3300 primes. One item is worked at a time.
// The answer appears on o_is_two_square_sum for exactly one cycle with
// o_valid high, in the cycle after the datapath reports the test done; the
// receiver cannot stall.
`timescale 1ns / 1ps
module sum_of_two_squares_test_top
    import sots_pkg::*;
#(
    parameter int SIEVE_LIMIT = SieveLimitDef,
    parameter int TABLE_DEPTH = TableDepthDef,
    parameter int VALUE_WIDTH = ValueWidthDef
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic                   o_is_two_square_sum
);
    t_cmd    w_cmd;
    t_status w_status;

    sots_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_is_two_square_sum)
    );

    sots_datapath #(
        .SIEVE_LIMIT (SIEVE_LIMIT),
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (i_value),
        .o_status (w_status)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$past(start && !busy)) else $error("result at accept");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than a cycle");
endmodule

[tb/tb_sum_of_two_squares_test_top.sv]
// Testbench for the sum-of-two-squares tester.
// Drives values in bursts, predicts each answer from its own sieve and checks it.
// Depends on sots_pkg and sum_of_two_squares_test_top.
`timescale 1ns / 1ps
module tb_sum_of_two_squares_test_top
    import sots_pkg::*;
;
    localparam int VW = ValueWidthDef;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [VW-1:0] i_value;
    logic          o_valid;
    logic          o_is_two_square_sum;

    logic [VW-1:0] pending_values[$];
    bit            expected_answers[$];
    bit            composite[SieveLimitDef];
    int            primes_3mod4[TableDepthDef];
    int            primes_3mod4_count;
    int            mismatches;
    int            gap_left;
    int            burst_left;

    sum_of_two_squares_test_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_value             (i_value),
        .o_valid             (o_valid),
        .o_is_two_square_sum (o_is_two_square_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void build_prime_table();
        longint i;
        longint j;
        for (i = 2; i * i < SieveLimitDef; i++) begin
            if (!composite[i]) begin
                for (j = i * i; j < SieveLimitDef; j += i) composite[j] = 1'b1;
            end
        end
        primes_3mod4_count = 0;
        for (i = 2; i < SieveLimitDef; i++) begin
            if (!composite[i] && (i % 4) == 3 && primes_3mod4_count < TableDepthDef) begin
                primes_3mod4[primes_3mod4_count] = int'(i);
                primes_3mod4_count++;
            end
        end
    endfunction

    function automatic bit predict_two_square(logic [VW-1:0] v);
        longint unsigned rest;
        longint unsigned p;
        bit              odd;
        rest = v;
        if (rest <= 1) return 1'b1;
        while (rest[0] == 1'b0) rest = rest >> 1;
        for (int k = 0; k < primes_3mod4_count; k++) begin
            p = primes_3mod4[k];
            if (p * p > rest) break;
            odd = 1'b0;
            while (rest % p == 0) begin
                rest = rest / p;
                odd = ~odd;
            end
            if (odd) return 1'b0;
        end
        if (rest > 1 && (rest % 4) == 3) return 1'b0;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        bit            next_start;
        logic [VW-1:0] next_value;
        next_start = start;
        next_value = i_value;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_answers.push_back(predict_two_square(i_value));
                next_start = 1'b0;
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_values.size() > 0) begin
                    next_start = 1'b1;
                    next_value = pending_values.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
        start <= next_start;
        i_value <= next_value;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer %0b", o_is_two_square_sum);
            end else begin
                bit want;
                want = expected_answers.pop_front();
                if (want !== o_is_two_square_sum) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer mismatch: expected %0b actual %0b",
                                 want, o_is_two_square_sum);
                end
            end
        end
    end

    initial begin
        #2_000_000_000;
        $display("tb_sum_of_two_squares_test_top: errors");
        $finish;
    end

    initial begin
        logic [VW-1:0] v;
        int            a;
        int            b;
        int            sel;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_value = '0;
        mismatches = 0;
        gap_left = 0;
        burst_left = 0;
        build_prime_table();

        // Directed values: trivial cases, powers of two, odd exponents, extremes.
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(32'd2);
        pending_values.push_back(32'd3);
        pending_values.push_back(32'd6);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd14);
        pending_values.push_back(32'd18);
        pending_values.push_back(32'd25);
        pending_values.push_back(32'd21);
        pending_values.push_back(32'd49 * 32'd5);
        pending_values.push_back(32'd65521);
        pending_values.push_back(32'd65519 * 32'd2);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'hFFFF_FFFB);
        pending_values.push_back(32'hFFFF_FFF1);
        pending_values.push_back(32'd65519 * 32'd65519);
        pending_values.push_back(32'd65521 * 32'd65519);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);

        for (int n = 0; n < 560; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                a = $urandom_range(0, 180);
                b = $urandom_range(0, 180);
                v = a * a + b * b;
                if ($urandom_range(0, 3) == 0) v = v * primes_3mod4[$urandom_range(0, 10)];
            end else if (sel < 80) begin
                v = $urandom_range(0, 65535);
            end else if (sel < 97) begin
                v = $urandom_range(0, 1 << 20);
            end else begin
                v = $urandom();
                v = v << $urandom_range(0, 12);
            end
            pending_values.push_back(v);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_values.size() == 0);
        @(posedge i_clk);
        while (start || expected_answers.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_sum_of_two_squares_test_top: clean");
        end else begin
            $display("tb_sum_of_two_squares_test_top: errors");
        end
        $finish;
    end
endmodule
